FILE: src/tsmf_pkg.sv
// Shared types, constants and helpers for the median temperature fusion block.
// No dependencies; imported by every module of the block.
package tsmf_pkg;

    localparam int MAX_SENSORS_DEF = 8;
    localparam int QUEUE_DEPTH_DEF = 4;

    // Temperatures in sixteenths of a degree
    localparam logic signed [11:0] T_DISCONNECTED = -12'sd2032;
    localparam logic signed [11:0] T_GLITCH       = 12'sd1360;
    localparam logic signed [12:0] FUSED_NONE     = -13'sd4064;

    localparam logic signed [11:0] MAX_VALID_RST = 12'sd2000;
    localparam logic [11:0]        GLITCH_GAP_RST = 12'd160;
    localparam logic [11:0]        OUTLIER_BAND_RST = 12'd24;

    // Configuration register indexes
    localparam logic [1:0] CFG_MAX_VALID    = 2'd0;
    localparam logic [1:0] CFG_GLITCH_GAP   = 2'd1;
    localparam logic [1:0] CFG_OUTLIER_BAND = 2'd2;

    typedef enum logic [1:0] {
        STATUS_MEDIAN   = 2'd0,
        STATUS_MEAN     = 2'd1,
        STATUS_NO_VALID = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_FILTER,
        ST_COUNT,
        ST_RESULT
    } back_state_t;

    typedef struct packed {
        logic signed [11:0] max_valid_temp;
        logic [11:0]        glitch_gap;
        logic [11:0]        outlier_band;
    } cfg_t;

    // One classified reading on its way from front to back
    typedef struct packed {
        logic signed [11:0] value;
        logic               usable;
        logic               store_en;
        logic               last;
    } qent_t;

    typedef struct packed {
        logic signed [12:0] fused;
        status_t            status;
        logic [3:0]         valid_count;
        logic [3:0]         outlier_count;
    } result_t;

    function automatic logic [12:0] absdiff12(logic signed [11:0] a, logic signed [11:0] b);
        logic signed [12:0] d;
        d = 13'(a) - 13'(b);
        return d[12] ? 13'(-d) : 13'(d);
    endfunction

endpackage

FILE: src/tsmf_front.sv
// Input side: accepts readings, tracks the per-round load count and classifies each reading.
// Depends on tsmf_pkg.
module tsmf_front #(
    parameter int MAX_SENSORS = tsmf_pkg::MAX_SENSORS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    input  logic [15:0]   s_axis_tdata,   // [11:0] reading, zero fill above
    input  logic          s_axis_tuser,   // [0] reading_missing
    input  logic          s_axis_tlast,   // last_reading
    output logic          q_valid,
    input  logic          q_ready,
    output tsmf_pkg::qent_t q_data
);
    import tsmf_pkg::*;

    localparam int CW = $clog2(MAX_SENSORS + 1);

    logic [CW-1:0] cnt_reg, cnt_next;
    logic          store_en;
    logic          accept;
    logic signed [11:0] value;

    assign value         = s_axis_tdata[11:0];
    assign store_en      = (32'(cnt_reg) < 32'(MAX_SENSORS));
    assign s_axis_tready = q_ready;
    assign q_valid       = s_axis_tvalid;
    assign accept        = s_axis_tvalid && q_ready;

    always_comb
    begin
        q_data.value    = value;
        q_data.usable   = !s_axis_tuser && (value != T_DISCONNECTED);
        q_data.store_en = store_en;
        q_data.last     = s_axis_tlast;
    end

    always_comb
    begin
        cnt_next = cnt_reg;
        if (accept)
        begin
            if (s_axis_tlast)
                cnt_next = '0;
            else if (store_en)
                cnt_next = cnt_reg + CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else
            cnt_reg <= cnt_next;
    end

endmodule

FILE: src/tsmf_fifo.sv
// Short queue of classified readings between front and back.
// Depends on tsmf_pkg for the entry type.
module tsmf_fifo #(
    parameter int DEPTH = tsmf_pkg::QUEUE_DEPTH_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push_valid,
    output logic            push_ready,
    input  tsmf_pkg::qent_t push_data,
    output logic            pop_valid,
    input  logic            pop_ready,
    output tsmf_pkg::qent_t pop_data
);
    import tsmf_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW = $clog2(DEPTH + 1);

    qent_t         mem [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next, rd_ptr_reg, rd_ptr_next;
    logic [NW-1:0] fill_reg, fill_next;
    logic          do_push, do_pop;

    assign push_ready = (32'(fill_reg) < 32'(DEPTH));
    assign pop_valid  = (fill_reg != '0);
    assign pop_data   = mem[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        if (do_push && !do_pop)
            fill_next = fill_reg + NW'(1);
        else if (do_pop && !do_push)
            fill_next = fill_reg - NW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= push_data;
    end

endmodule

FILE: src/tsmf_back.sv
// Evaluation side: stores a round, filters it one entry per cycle into an insertion-sorted
// array, counts outliers against the upper median and holds the result. Depends on tsmf_pkg.
module tsmf_back #(
    parameter int MAX_SENSORS = tsmf_pkg::MAX_SENSORS_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  tsmf_pkg::cfg_t  cfg,
    input  logic            q_valid,
    output logic            q_ready,
    input  tsmf_pkg::qent_t q_data,
    output logic            m_axis_tvalid,
    input  logic            m_axis_tready,
    output logic [23:0]     m_axis_tdata,  // [12:0] fused_temp, [16:13] valid_count,
                                           // [20:17] outlier_count, zero fill above
    output logic [1:0]      m_axis_tuser   // [1:0] status
);
    import tsmf_pkg::*;

    localparam int IW  = (MAX_SENSORS > 1) ? $clog2(MAX_SENSORS) : 1;
    localparam int CW  = $clog2(MAX_SENSORS + 1);
    localparam int NB1 = (MAX_SENSORS > 1) ? 1 : 0;  // neighbour of sensor 0

    back_state_t state_reg, state_next;

    logic [CW-1:0] cnt_reg, cnt_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic [CW-1:0] nsurv_reg, nsurv_next;
    logic [CW-1:0] outl_reg, outl_next;

    logic signed [11:0] val_mem  [MAX_SENSORS];
    logic               use_mem  [MAX_SENSORS];
    logic signed [11:0] surv_reg [MAX_SENSORS];
    logic signed [11:0] surv_next [MAX_SENSORS];

    logic    out_valid_reg, out_valid_next;
    result_t out_reg;
    result_t result;
    logic    out_load;

    logic    pop, wr_en;
    logic    filter_done, count_done;
    logic signed [11:0] cur_val, nb_val, med, cur_surv;
    logic    cur_use, nb_use, nb_present, glitch_drop, survive, ins_en, outl_hit;
    logic [CW-1:0] med_idx;

    // ---------------- filter path ----------------
    assign cur_val    = val_mem[idx_reg[IW-1:0]];
    assign cur_use    = use_mem[idx_reg[IW-1:0]];
    assign nb_val     = (idx_reg == '0) ? val_mem[NB1] : val_mem[0];
    assign nb_use     = (idx_reg == '0) ? use_mem[NB1] : use_mem[0];
    assign nb_present = (idx_reg == '0) ? (32'(cnt_reg) > 32'd1) : 1'b1;
    assign glitch_drop = (cur_val == T_GLITCH) && nb_present && nb_use
                         && (absdiff12(cur_val, nb_val) > {1'b0, cfg.glitch_gap});
    assign survive     = cur_use && !glitch_drop && !(cur_val > cfg.max_valid_temp);
    assign filter_done = (idx_reg == cnt_reg);
    assign ins_en      = (state_reg == ST_FILTER) && !filter_done && survive;

    // Insertion into the sorted array: every slot decides for itself in parallel
    always_comb
    begin
        for (int k = 0; k < MAX_SENSORS; k++)
            surv_next[k] = surv_reg[k];
        if (ins_en)
        begin
            if ((nsurv_reg == '0) || (surv_reg[0] > cur_val))
                surv_next[0] = cur_val;
            for (int k = 1; k < MAX_SENSORS; k++)
            begin
                if ((32'(k) <= 32'(nsurv_reg))
                    && ((32'(k) == 32'(nsurv_reg)) || (surv_reg[k] > cur_val)))
                    surv_next[k] = (surv_reg[k-1] > cur_val) ? surv_reg[k-1] : cur_val;
            end
        end
    end

    // ---------------- outlier count path ----------------
    assign med_idx    = nsurv_reg >> 1;
    assign med        = surv_reg[med_idx[IW-1:0]];
    assign cur_surv   = surv_reg[idx_reg[IW-1:0]];
    assign outl_hit   = absdiff12(cur_surv, med) > {1'b0, cfg.outlier_band};
    assign count_done = (idx_reg == nsurv_reg);

    // ---------------- result ----------------
    always_comb
    begin
        result.valid_count   = (32'(nsurv_reg) > 32'd15) ? 4'd15 : 4'(nsurv_reg);
        result.outlier_count = 4'd0;
        if (nsurv_reg == '0)
        begin
            result.fused  = FUSED_NONE;
            result.status = STATUS_NO_VALID;
        end
        else if (32'(nsurv_reg) >= 32'd3)
        begin
            result.fused         = {med, 1'b0};
            result.status        = STATUS_MEDIAN;
            result.outlier_count = (32'(outl_reg) > 32'd15) ? 4'd15 : 4'(outl_reg);
        end
        else if (32'(nsurv_reg) == 32'd1)
        begin
            result.fused  = {surv_reg[0], 1'b0};
            result.status = STATUS_MEAN;
        end
        else
        begin
            result.fused  = 13'(surv_reg[0]) + 13'(surv_reg[NB1]);
            result.status = STATUS_MEAN;
        end
    end

    // ---------------- control ----------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_LOAD:
                if (q_valid && q_data.last)
                    state_next = ST_FILTER;
            ST_FILTER:
                if (filter_done)
                    state_next = ST_COUNT;
            ST_COUNT:
                if (count_done)
                    state_next = ST_RESULT;
            ST_RESULT:
                if (!out_valid_reg || m_axis_tready)
                    state_next = ST_LOAD;
            default:
                state_next = ST_LOAD;
        endcase
    end

    always_comb
    begin
        q_ready    = (state_reg == ST_LOAD);
        pop        = q_ready && q_valid;
        wr_en      = pop && q_data.store_en;
        out_load   = (state_reg == ST_RESULT) && (!out_valid_reg || m_axis_tready);
        cnt_next   = cnt_reg;
        idx_next   = idx_reg;
        nsurv_next = nsurv_reg;
        outl_next  = outl_reg;
        unique case (state_reg)
            ST_LOAD:
            begin
                if (wr_en)
                    cnt_next = cnt_reg + CW'(1);
                idx_next   = '0;
                nsurv_next = '0;
                outl_next  = '0;
            end
            ST_FILTER:
            begin
                if (filter_done)
                    idx_next = '0;
                else
                    idx_next = idx_reg + CW'(1);
                if (ins_en)
                    nsurv_next = nsurv_reg + CW'(1);
            end
            ST_COUNT:
            begin
                if (!count_done)
                begin
                    idx_next = idx_reg + CW'(1);
                    if (outl_hit)
                        outl_next = outl_reg + CW'(1);
                end
            end
            ST_RESULT:
            begin
                if (out_load)
                    cnt_next = '0;
            end
            default:
            begin
                cnt_next = '0;
            end
        endcase
        if (out_load)
            out_valid_next = 1'b1;
        else if (m_axis_tready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOAD;
            cnt_reg       <= '0;
            idx_reg       <= '0;
            nsurv_reg     <= '0;
            outl_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            idx_reg       <= idx_next;
            nsurv_reg     <= nsurv_next;
            outl_reg      <= outl_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            val_mem[cnt_reg[IW-1:0]] <= q_data.value;
            use_mem[cnt_reg[IW-1:0]] <= q_data.usable;
        end
        for (int k = 0; k < MAX_SENSORS; k++)
            surv_reg[k] <= surv_next[k];
        if (out_load)
            out_reg <= result;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {3'b000, out_reg.outlier_count, out_reg.valid_count, out_reg.fused};
    assign m_axis_tuser  = out_reg.status;

endmodule

FILE: src/temp_sensor_median_fusion.sv
// Median temperature fusion, top level: configuration registers, front, queue and back.
// Depends on tsmf_pkg, tsmf_front, tsmf_fifo and tsmf_back.
//
// Usage: readings stream in on s_axis, one sensor per transfer, tdata[11:0] in 1/16 C,
// tuser the missing flag, tlast on the final reading of a round. Readings past
// MAX_SENSORS are dropped; tlast on one of them still closes the round. One result per
// round leaves on m_axis: tdata holds fused temperature (1/32 C), valid and outlier
// counts, tuser the status (median, mean, no valid).
// Configuration writes (cfg_valid/cfg_index/cfg_data) are always taken, cfg_ready being high, and
// are meant for idle periods between rounds.
// Flow: the front takes one reading per cycle while the queue has room. After tlast the
// back evaluates the round in order: one pass over the stored readings with one
// insertion-sort step each, one pass over the survivors for the outlier count, then
// the output register loads. The back takes no new reading while it evaluates, so
// the queue depth sets how far the next round can run ahead.
// A stalled receiver holds the result in the output register; the back waits for it.
// Reset empties the queue, clears the round and restores the register defaults.
module temp_sensor_median_fusion #(
    parameter int MAX_SENSORS = tsmf_pkg::MAX_SENSORS_DEF,
    parameter int QUEUE_DEPTH = tsmf_pkg::QUEUE_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [11:0] reading, zero fill above
    input  logic        s_axis_tuser,   // [0] reading_missing
    input  logic        s_axis_tlast,   // last_reading
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [12:0] fused_temp, [16:13] valid_count,
                                        // [20:17] outlier_count, zero fill above
    output logic [1:0]  m_axis_tuser,   // [1:0] status
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [11:0] cfg_data
);
    import tsmf_pkg::*;

    cfg_t  cfg_reg, cfg_next;
    logic  q_in_valid, q_in_ready, q_out_valid, q_out_ready;
    qent_t q_in_data, q_out_data;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_MAX_VALID:    cfg_next.max_valid_temp = cfg_data;
                CFG_GLITCH_GAP:   cfg_next.glitch_gap     = cfg_data;
                CFG_OUTLIER_BAND: cfg_next.outlier_band   = cfg_data;
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.max_valid_temp <= MAX_VALID_RST;
            cfg_reg.glitch_gap     <= GLITCH_GAP_RST;
            cfg_reg.outlier_band   <= OUTLIER_BAND_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    tsmf_front #(
        .MAX_SENSORS(MAX_SENSORS)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .q_valid       (q_in_valid),
        .q_ready       (q_in_ready),
        .q_data        (q_in_data)
    );

    tsmf_fifo #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (q_in_valid),
        .push_ready (q_in_ready),
        .push_data  (q_in_data),
        .pop_valid  (q_out_valid),
        .pop_ready  (q_out_ready),
        .pop_data   (q_out_data)
    );

    tsmf_back #(
        .MAX_SENSORS(MAX_SENSORS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg_reg),
        .q_valid       (q_out_valid),
        .q_ready       (q_out_ready),
        .q_data        (q_out_data),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule
